// ----- hdl/v3a_pkg.sv -----
// Shared types and constants for the three-component vector arithmetic unit.
package v3a_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int WORD_BITS_DEF = 32;

    typedef enum logic [2:0] {
        ACT_ADD   = 3'd0,
        ACT_SUB   = 3'd1,
        ACT_SCALE = 3'd2,
        ACT_DIV   = 3'd3,
        ACT_DOT   = 3'd4,
        ACT_CROSS = 3'd5,
        ACT_MAG   = 3'd6,
        ACT_NORM  = 3'd7
    } t_action;

    typedef struct packed {
        logic    valid;
        t_action action;
    } t_ctl;

endpackage

// ----- hdl/v3a_front.sv -----
// Multiplier and combining stages that form add, sub, scale, dot, cross and sum of squares.
module v3a_front #(
    parameter int W = v3a_pkg::WORD_BITS_DEF,
    parameter int F = v3a_pkg::FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  v3a_pkg::t_ctl         i_ctl,
    input  logic signed [W-1:0]   i_a_x,
    input  logic signed [W-1:0]   i_a_y,
    input  logic signed [W-1:0]   i_a_z,
    input  logic signed [W-1:0]   i_b_x,
    input  logic signed [W-1:0]   i_b_y,
    input  logic signed [W-1:0]   i_b_z,
    input  logic signed [W-1:0]   i_s,
    output v3a_pkg::t_ctl         o_ctl,
    output logic [2*W-1:0]        o_sumsq,
    output logic [8*W+1:0]        o_data
);
    import v3a_pkg::*;

    localparam int EW = 2 * W + 2;
    localparam logic [W-1:0] MAXW = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINW = {1'b1, {(W-1){1'b0}}};

    logic signed [W-1:0]   in_a [3];
    logic signed [W-1:0]   in_b [3];
    logic signed [W-1:0]   mx [3];
    logic signed [W-1:0]   my [3];
    logic signed [2*W-1:0] n_p [6];

    t_ctl                  r_ctl1;
    logic signed [W-1:0]   r_a [3];
    logic signed [W-1:0]   r_b [3];
    logic signed [W-1:0]   r_s;
    logic signed [2*W-1:0] r_p [6];

    t_ctl                  r_ctl2;
    logic [2*W-1:0]        r_sumsq;
    logic [8*W+1:0]        r_data;

    logic [W-1:0]          n_pre [3];
    logic [W-1:0]          n_pre_s;
    logic                  n_ovf;
    logic                  n_dz;
    logic [EW-1:0]         n_sumsq;

    function automatic logic [W:0] f_sat(input logic signed [EW-1:0] v);
        logic ovf;
        ovf = !((&v[EW-1:W-1]) || !(|v[EW-1:W-1]));
        if (!ovf) begin
            return {1'b0, v[W-1:0]};
        end else if (v[EW-1]) begin
            return {1'b1, MINW};
        end else begin
            return {1'b1, MAXW};
        end
    endfunction

    assign in_a[0] = i_a_x;
    assign in_a[1] = i_a_y;
    assign in_a[2] = i_a_z;
    assign in_b[0] = i_b_x;
    assign in_b[1] = i_b_y;
    assign in_b[2] = i_b_z;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            mx[i] = in_a[i];
            case (i_ctl.action)
                ACT_SCALE: my[i] = i_s;
                ACT_MAG, ACT_NORM: my[i] = in_a[i];
                default: my[i] = in_b[i];
            endcase
        end
        if (i_ctl.action == ACT_CROSS) begin
            mx[0] = in_a[2];
            my[0] = in_b[1];
            mx[1] = in_a[0];
            my[1] = in_b[2];
            mx[2] = in_a[1];
            my[2] = in_b[0];
        end
        for (int i = 0; i < 3; i++) begin
            n_p[i] = (2*W)'(mx[i]) * (2*W)'(my[i]);
        end
        n_p[3] = (2*W)'(in_a[1]) * (2*W)'(in_b[2]);
        n_p[4] = (2*W)'(in_a[2]) * (2*W)'(in_b[0]);
        n_p[5] = (2*W)'(in_a[0]) * (2*W)'(in_b[1]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
        end else if (i_en) begin
            r_ctl1 <= i_ctl;
        end
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_a[i] <= in_a[i];
                r_b[i] <= in_b[i];
            end
            r_s <= i_s;
            for (int i = 0; i < 6; i++) begin
                r_p[i] <= n_p[i];
            end
        end
    end

    always_comb begin
        logic signed [EW-1:0] ea;
        logic signed [EW-1:0] eb;
        logic signed [EW-1:0] v;
        logic [W:0]           sv;
        logic signed [EW-1:0] psum;
        psum = EW'(r_p[0]) + EW'(r_p[1]) + EW'(r_p[2]);
        n_sumsq = psum;
        n_ovf = 1'b0;
        n_dz = 1'b0;
        n_pre_s = '0;
        for (int i = 0; i < 3; i++) begin
            n_pre[i] = '0;
            ea = EW'(r_a[i]);
            eb = EW'(r_b[i]);
            case (r_ctl1.action)
                ACT_ADD: v = ea + eb;
                ACT_SUB: v = ea - eb;
                ACT_SCALE: v = EW'(r_p[i]) >>> F;
                ACT_CROSS: v = (EW'(r_p[3+i]) - EW'(r_p[i])) >>> F;
                default: v = '0;
            endcase
            sv = f_sat(v);
            n_pre[i] = sv[W-1:0];
            n_ovf = n_ovf | sv[W];
        end
        if (r_ctl1.action == ACT_DOT) begin
            sv = f_sat(psum >>> F);
            n_pre_s = sv[W-1:0];
            n_ovf = sv[W];
        end
        if (r_ctl1.action == ACT_DIV && r_s == '0) begin
            n_dz = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl2 <= '0;
        end else if (i_en) begin
            r_ctl2 <= r_ctl1;
        end
        if (i_en) begin
            r_sumsq <= n_sumsq[2*W-1:0];
            r_data <= {r_a[0], r_a[1], r_a[2], r_s, n_pre[0], n_pre[1], n_pre[2],
                       n_pre_s, n_ovf, n_dz};
        end
    end

    assign o_ctl = r_ctl2;
    assign o_sumsq = r_sumsq;
    assign o_data = r_data;

endmodule

// ----- hdl/v3a_sqrt_cell.sv -----
// One square-root cell that settles one root bit from two radicand bits.
module v3a_sqrt_cell #(
    parameter int W  = v3a_pkg::WORD_BITS_DEF,
    parameter int DW = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  v3a_pkg::t_ctl   i_ctl,
    input  logic [2*W-1:0]  i_sq,
    input  logic [W:0]      i_rem,
    input  logic [W-1:0]    i_root,
    input  logic [DW-1:0]   i_data,
    output v3a_pkg::t_ctl   o_ctl,
    output logic [2*W-1:0]  o_sq,
    output logic [W:0]      o_rem,
    output logic [W-1:0]    o_root,
    output logic [DW-1:0]   o_data
);
    import v3a_pkg::*;

    t_ctl           r_ctl;
    logic [2*W-1:0] r_sq;
    logic [W:0]     r_rem;
    logic [W-1:0]   r_root;
    logic [DW-1:0]  r_data;

    logic [W+2:0]   rem_sh;
    logic [W+2:0]   trial;
    logic [W+2:0]   diff;
    logic           ge;

    assign rem_sh = {i_rem, i_sq[2*W-1:2*W-2]};
    assign trial  = {1'b0, i_root, 2'b01};
    assign ge     = rem_sh >= trial;
    assign diff   = ge ? (rem_sh - trial) : rem_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
        if (i_en) begin
            r_sq   <= {i_sq[2*W-3:0], 2'b00};
            r_rem  <= diff[W:0];
            r_root <= {i_root[W-2:0], ge};
            r_data <= i_data;
        end
    end

    assign o_ctl  = r_ctl;
    assign o_sq   = r_sq;
    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_data = r_data;

endmodule

// ----- hdl/v3a_div_cell.sv -----
// One divider cell that settles one quotient bit in each of three lanes.
module v3a_div_cell #(
    parameter int W  = v3a_pkg::WORD_BITS_DEF,
    parameter int Q  = 48,
    parameter int DW = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  v3a_pkg::t_ctl       i_ctl,
    input  logic [W-1:0]        i_den,
    input  logic [2:0][Q-1:0]   i_num,
    input  logic [2:0][W-1:0]   i_rem,
    input  logic [2:0][Q-1:0]   i_quo,
    input  logic [DW-1:0]       i_data,
    output v3a_pkg::t_ctl       o_ctl,
    output logic [W-1:0]        o_den,
    output logic [2:0][Q-1:0]   o_num,
    output logic [2:0][W-1:0]   o_rem,
    output logic [2:0][Q-1:0]   o_quo,
    output logic [DW-1:0]       o_data
);
    import v3a_pkg::*;

    t_ctl              r_ctl;
    logic [W-1:0]      r_den;
    logic [2:0][Q-1:0] r_num;
    logic [2:0][W-1:0] r_rem;
    logic [2:0][Q-1:0] r_quo;
    logic [DW-1:0]     r_data;

    logic [2:0][W-1:0] n_rem;
    logic [2:0]        qbit;

    always_comb begin
        logic [W:0] r2;
        for (int k = 0; k < 3; k++) begin
            r2 = {i_rem[k], i_num[k][Q-1]};
            qbit[k] = r2 >= {1'b0, i_den};
            if (qbit[k]) begin
                r2 = r2 - {1'b0, i_den};
            end
            n_rem[k] = r2[W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
        if (i_en) begin
            r_den  <= i_den;
            r_data <= i_data;
            for (int k = 0; k < 3; k++) begin
                r_num[k] <= {i_num[k][Q-2:0], 1'b0};
                r_rem[k] <= n_rem[k];
                r_quo[k] <= {i_quo[k][Q-2:0], qbit[k]};
            end
        end
    end

    assign o_ctl  = r_ctl;
    assign o_den  = r_den;
    assign o_num  = r_num;
    assign o_rem  = r_rem;
    assign o_quo  = r_quo;
    assign o_data = r_data;

endmodule

// ----- hdl/vector3_alu.sv -----
// Top level of the three-component fixed-point vector arithmetic unit.
// The unit accepts one request per cycle while o_stall is low and returns one result per request, in order.
// Every request runs through the whole pipeline: two multiply and combine stages, a row of
// WORD_BITS square-root cells (one root bit each), one divider setup stage, a row of
// WORD_BITS + FRAC_BITS divider cells (one quotient bit each) and the output register.
// While a result waits at the output under stall, the whole pipeline holds.
module vector3_alu #(
    parameter int WORD_BITS = v3a_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = v3a_pkg::FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [2:0]                   i_action,
    input  logic signed [WORD_BITS-1:0]  i_a_x,
    input  logic signed [WORD_BITS-1:0]  i_a_y,
    input  logic signed [WORD_BITS-1:0]  i_a_z,
    input  logic signed [WORD_BITS-1:0]  i_b_x,
    input  logic signed [WORD_BITS-1:0]  i_b_y,
    input  logic signed [WORD_BITS-1:0]  i_b_z,
    input  logic signed [WORD_BITS-1:0]  i_scalar_in,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [WORD_BITS-1:0]  o_r_x,
    output logic signed [WORD_BITS-1:0]  o_r_y,
    output logic signed [WORD_BITS-1:0]  o_r_z,
    output logic signed [WORD_BITS-1:0]  o_r_scalar,
    output logic                         o_overflow,
    output logic                         o_div_zero
);
    import v3a_pkg::*;

    localparam int W  = WORD_BITS;
    localparam int F  = FRAC_BITS;
    localparam int Q  = W + F;
    localparam int DW = 8 * W + 2;
    localparam int D2 = 4 * W + 6;
    localparam logic [W-1:0] MAXW = {1'b0, {(W-1){1'b1}}};
    localparam logic [Q-1:0] MAXQ = Q'(MAXW);
    localparam logic [Q-1:0] MINQ = Q'({1'b1, {(W-1){1'b0}}});

    logic en;
    t_ctl in_ctl;

    t_ctl           sq_ctl  [W+1];
    logic [2*W-1:0] sq_s    [W+1];
    logic [W:0]     sq_rem  [W+1];
    logic [W-1:0]   sq_root [W+1];
    logic [DW-1:0]  sq_data [W+1];

    t_ctl              dv_ctl  [Q+1];
    logic [W-1:0]      dv_den  [Q+1];
    logic [2:0][Q-1:0] dv_num  [Q+1];
    logic [2:0][W-1:0] dv_rem  [Q+1];
    logic [2:0][Q-1:0] dv_quo  [Q+1];
    logic [D2-1:0]     dv_data [Q+1];

    t_ctl              r_e_ctl;
    logic [W-1:0]      r_e_den;
    logic [2:0][Q-1:0] r_e_num;
    logic [D2-1:0]     r_e_data;

    t_ctl              n_e_ctl;
    logic [W-1:0]      n_e_den;
    logic [2:0][Q-1:0] n_e_num;
    logic [D2-1:0]     n_e_data;

    logic              r_o_valid;
    logic [W-1:0]      r_o_x;
    logic [W-1:0]      r_o_y;
    logic [W-1:0]      r_o_z;
    logic [W-1:0]      r_o_s;
    logic              r_o_ovf;
    logic              r_o_dz;

    logic [W-1:0]      n_o_vec [3];
    logic              n_o_ovf;

    assign en      = !(r_o_valid && i_stall);
    assign o_stall = r_o_valid && i_stall;
    assign in_ctl  = '{valid: i_valid, action: t_action'(i_action)};

    v3a_front #(.W(W), .F(F)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctl   (in_ctl),
        .i_a_x   (i_a_x),
        .i_a_y   (i_a_y),
        .i_a_z   (i_a_z),
        .i_b_x   (i_b_x),
        .i_b_y   (i_b_y),
        .i_b_z   (i_b_z),
        .i_s     (i_scalar_in),
        .o_ctl   (sq_ctl[0]),
        .o_sumsq (sq_s[0]),
        .o_data  (sq_data[0])
    );

    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;

    for (genvar g = 0; g < W; g++) begin : g_sqrt
        v3a_sqrt_cell #(.W(W), .DW(DW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_ctl   (sq_ctl[g]),
            .i_sq    (sq_s[g]),
            .i_rem   (sq_rem[g]),
            .i_root  (sq_root[g]),
            .i_data  (sq_data[g]),
            .o_ctl   (sq_ctl[g+1]),
            .o_sq    (sq_s[g+1]),
            .o_rem   (sq_rem[g+1]),
            .o_root  (sq_root[g+1]),
            .o_data  (sq_data[g+1])
        );
    end

    always_comb begin
        logic [W-1:0] a [3];
        logic [W-1:0] s;
        logic [W-1:0] pre [3];
        logic [W-1:0] pre_s;
        logic         ovf;
        logic         dz;
        logic [W-1:0] m;
        logic [W-1:0] abs_s;
        logic [W-1:0] abs_a;
        logic [W-1:0] d_raw;
        logic         is_div;
        logic         den_zero;
        logic         use_div;
        logic         d_sign;
        logic [2:0]   neg;
        a[0]   = sq_data[W][8*W+1 -: W];
        a[1]   = sq_data[W][7*W+1 -: W];
        a[2]   = sq_data[W][6*W+1 -: W];
        s      = sq_data[W][5*W+1 -: W];
        pre[0] = sq_data[W][4*W+1 -: W];
        pre[1] = sq_data[W][3*W+1 -: W];
        pre[2] = sq_data[W][2*W+1 -: W];
        pre_s  = sq_data[W][W+1 -: W];
        ovf    = sq_data[W][1];
        dz     = sq_data[W][0];
        m      = sq_root[W];
        is_div = sq_ctl[W].action == ACT_DIV;
        abs_s  = s[W-1] ? (~s + 1'b1) : s;
        d_raw  = is_div ? abs_s : m;
        den_zero = d_raw == '0;
        use_div = (is_div || sq_ctl[W].action == ACT_NORM) && !den_zero;
        d_sign = is_div && s[W-1];
        if (sq_ctl[W].action == ACT_MAG) begin
            if (m[W-1]) begin
                pre_s = MAXW;
                ovf   = 1'b1;
            end else begin
                pre_s = m;
            end
        end
        if (sq_ctl[W].action == ACT_NORM && den_zero) begin
            pre[0] = a[0];
            pre[1] = a[1];
            pre[2] = a[2];
        end
        for (int k = 0; k < 3; k++) begin
            abs_a = a[k][W-1] ? (~a[k] + 1'b1) : a[k];
            n_e_num[k] = Q'(abs_a) << F;
            neg[k] = a[k][W-1] ^ d_sign;
        end
        n_e_ctl  = sq_ctl[W];
        n_e_den  = d_raw;
        n_e_data = {pre[0], pre[1], pre[2], pre_s, ovf, dz, use_div, neg};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_ctl <= '0;
        end else if (en) begin
            r_e_ctl <= n_e_ctl;
        end
        if (en) begin
            r_e_den  <= n_e_den;
            r_e_num  <= n_e_num;
            r_e_data <= n_e_data;
        end
    end

    assign dv_ctl[0]  = r_e_ctl;
    assign dv_den[0]  = r_e_den;
    assign dv_num[0]  = r_e_num;
    assign dv_rem[0]  = '0;
    assign dv_quo[0]  = '0;
    assign dv_data[0] = r_e_data;

    for (genvar g = 0; g < Q; g++) begin : g_div
        v3a_div_cell #(.W(W), .Q(Q), .DW(D2)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_ctl   (dv_ctl[g]),
            .i_den   (dv_den[g]),
            .i_num   (dv_num[g]),
            .i_rem   (dv_rem[g]),
            .i_quo   (dv_quo[g]),
            .i_data  (dv_data[g]),
            .o_ctl   (dv_ctl[g+1]),
            .o_den   (dv_den[g+1]),
            .o_num   (dv_num[g+1]),
            .o_rem   (dv_rem[g+1]),
            .o_quo   (dv_quo[g+1]),
            .o_data  (dv_data[g+1])
        );
    end

    always_comb begin
        logic [Q-1:0] q;
        logic [Q-1:0] qn;
        logic         neg;
        logic         use_div;
        use_div = dv_data[Q][3];
        n_o_ovf = dv_data[Q][5];
        if (use_div) begin
            n_o_ovf = 1'b0;
        end
        for (int k = 0; k < 3; k++) begin
            n_o_vec[k] = dv_data[Q][D2-1-k*W -: W];
            q   = dv_quo[Q][k];
            neg = dv_data[Q][k];
            qn  = ~q + 1'b1;
            if (use_div) begin
                if (neg && q > MINQ) begin
                    n_o_vec[k] = {1'b1, {(W-1){1'b0}}};
                    n_o_ovf = 1'b1;
                end else if (!neg && q > MAXQ) begin
                    n_o_vec[k] = MAXW;
                    n_o_ovf = 1'b1;
                end else begin
                    n_o_vec[k] = neg ? qn[W-1:0] : q[W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_o_valid <= dv_ctl[Q].valid;
        end
        if (en) begin
            r_o_x   <= n_o_vec[0];
            r_o_y   <= n_o_vec[1];
            r_o_z   <= n_o_vec[2];
            r_o_s   <= dv_data[Q][W+5 -: W];
            r_o_ovf <= n_o_ovf;
            r_o_dz  <= dv_data[Q][4];
        end
    end

    assign o_valid    = r_o_valid;
    assign o_r_x      = r_o_x;
    assign o_r_y      = r_o_y;
    assign o_r_z      = r_o_z;
    assign o_r_scalar = r_o_s;
    assign o_overflow = r_o_ovf;
    assign o_div_zero = r_o_dz;

`ifndef NO_ASSERTIONS
    a_dz_zero_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_div_zero |-> o_r_x == '0 && o_r_y == '0 && o_r_z == '0)
        else $error("divide by zero gave a nonzero vector");
    a_dz_no_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_div_zero |-> !o_overflow)
        else $error("divide by zero also flagged overflow");
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_r_x) && $stable(o_r_scalar))
        else $error("stalled result changed");
    a_stall_follows_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a held result");
`endif

endmodule
